// ===== rtl/irfpe_pkg.sv =====
// ============================================================================
// irfpe_pkg
// Shared types and constants of the infrared frame pulse encoder.
// ============================================================================
`default_nettype none

package irfpe_pkg;

	localparam int DUR_BITS    = 15;
	localparam int FIELD_BITS  = 15;
	localparam int WIDTH_BITS  = 4;
	localparam int TIMING_BITS = 2 * DUR_BITS;
	localparam int COUNT_BITS  = 6;
	localparam int FLAG_BITS   = 3;
	localparam int INDEX_BITS  = 3;

	typedef logic [INDEX_BITS-1:0] cfg_index_t;

	localparam cfg_index_t REG_LEADER   = 3'd0;
	localparam cfg_index_t REG_ONE      = 3'd1;
	localparam cfg_index_t REG_ZERO     = 3'd2;
	localparam cfg_index_t REG_STOP     = 3'd3;
	localparam cfg_index_t REG_ADDR_W   = 3'd4;
	localparam cfg_index_t REG_CMD_W    = 3'd5;
	localparam cfg_index_t REG_FORMAT   = 3'd6;
	localparam cfg_index_t REG_EXPECTED = 3'd7;

	localparam int FLAG_ADDR_INV = 0;
	localparam int FLAG_CMD_INV  = 1;
	localparam int FLAG_STOP     = 2;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_LEADER   = 7'b0000010,
		PH_ADDR     = 7'b0000100,
		PH_ADDR_INV = 7'b0001000,
		PH_CMD      = 7'b0010000,
		PH_CMD_INV  = 7'b0100000,
		PH_STOP     = 7'b1000000
	} phase_t;

endpackage

`default_nettype wire

// ===== rtl/ir_frame_pulse_encoder.sv =====
// ============================================================================
// ir_frame_pulse_encoder
// Serializes an address and a command into a frame of mark/space pulse items.
// ============================================================================
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_ready    address, command
//  out      source     out_valid / out_ready  mark_ticks, space_ticks,
//                                             last_item, frame_ok
//  cfg      sink       cfg_we                 cfg_index, cfg_data
//
//  A frame holds 1 to 62 items. After the transfer is taken, the phase
//  sequencer gives one item per cycle unless the output register is stalled,
//  and shifts the address and command out one bit per item.
//  A new frame is taken once the last item has entered the output register.
//  A stalled output register holds the sequencer in place.
//  arst_n clears the sequencer and the output valid; registers take reset values.
`default_nettype none

module ir_frame_pulse_encoder
	import irfpe_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [INDEX_BITS-1:0]  cfg_index,
	input  wire logic [TIMING_BITS-1:0] cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [FIELD_BITS-1:0]  address,
	input  wire logic [FIELD_BITS-1:0]  command,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [DUR_BITS-1:0]         mark_ticks,
	output logic [DUR_BITS-1:0]         space_ticks,
	output logic                        last_item,
	output logic                        frame_ok
);

	logic [TIMING_BITS-1:0] leader_q, one_q, zero_q, stop_q;
	logic [WIDTH_BITS-1:0]  addr_w_q, cmd_w_q;
	logic [FLAG_BITS-1:0]   flags_q;
	logic [COUNT_BITS-1:0]  expected_q;

	phase_t                 phase_q, phase_after;
	logic [FIELD_BITS-1:0]  addr_hold_q, cmd_hold_q, addr_sh_q, cmd_sh_q;
	logic [WIDTH_BITS-1:0]  bitpos_q;
	logic [COUNT_BITS-1:0]  cnt_q, total_q, total_d;

	logic                   out_valid_q, last_q, ok_q;
	logic [DUR_BITS-1:0]    mark_q, space_q;

	logic                   in_xfer, slot_free, emit, bit_end;
	logic [TIMING_BITS-1:0] timing;
	logic                   is_last;

	assign in_ready  = (phase_q == PH_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (phase_q != PH_IDLE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_q   <= '0;
			one_q      <= '0;
			zero_q     <= '0;
			stop_q     <= '0;
			addr_w_q   <= WIDTH_BITS'(8);
			cmd_w_q    <= WIDTH_BITS'(8);
			flags_q    <= FLAG_BITS'(7);
			expected_q <= COUNT_BITS'(34);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEADER:   leader_q   <= cfg_data;
				REG_ONE:      one_q      <= cfg_data;
				REG_ZERO:     zero_q     <= cfg_data;
				REG_STOP:     stop_q     <= cfg_data;
				REG_ADDR_W:   addr_w_q   <= cfg_data[WIDTH_BITS-1:0];
				REG_CMD_W:    cmd_w_q    <= cfg_data[WIDTH_BITS-1:0];
				REG_FORMAT:   flags_q    <= cfg_data[FLAG_BITS-1:0];
				REG_EXPECTED: expected_q <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		total_d = COUNT_BITS'(1)
			+ (flags_q[FLAG_ADDR_INV] ? {1'b0, addr_w_q, 1'b0}
			                          : {2'b00, addr_w_q})
			+ (flags_q[FLAG_CMD_INV]  ? {1'b0, cmd_w_q, 1'b0}
			                          : {2'b00, cmd_w_q})
			+ COUNT_BITS'(flags_q[FLAG_STOP]);
	end

	always_comb begin
		phase_after = PH_IDLE;
		case (phase_q)
			PH_LEADER: begin
				if (addr_w_q != '0)
					phase_after = PH_ADDR;
				else if (cmd_w_q != '0)
					phase_after = PH_CMD;
				else if (flags_q[FLAG_STOP])
					phase_after = PH_STOP;
			end
			PH_ADDR: begin
				if (flags_q[FLAG_ADDR_INV])
					phase_after = PH_ADDR_INV;
				else if (cmd_w_q != '0)
					phase_after = PH_CMD;
				else if (flags_q[FLAG_STOP])
					phase_after = PH_STOP;
			end
			PH_ADDR_INV: begin
				if (cmd_w_q != '0)
					phase_after = PH_CMD;
				else if (flags_q[FLAG_STOP])
					phase_after = PH_STOP;
			end
			PH_CMD: begin
				if (flags_q[FLAG_CMD_INV])
					phase_after = PH_CMD_INV;
				else if (flags_q[FLAG_STOP])
					phase_after = PH_STOP;
			end
			PH_CMD_INV: begin
				if (flags_q[FLAG_STOP])
					phase_after = PH_STOP;
			end
			default: phase_after = PH_IDLE;
		endcase
	end

	always_comb begin
		timing  = leader_q;
		bit_end = 1'b1;
		case (phase_q)
			PH_LEADER: timing = leader_q;
			PH_ADDR: begin
				timing  = addr_sh_q[0] ? one_q : zero_q;
				bit_end = (bitpos_q + WIDTH_BITS'(1)) == addr_w_q;
			end
			PH_ADDR_INV: begin
				timing  = addr_sh_q[0] ? zero_q : one_q;
				bit_end = (bitpos_q + WIDTH_BITS'(1)) == addr_w_q;
			end
			PH_CMD: begin
				timing  = cmd_sh_q[0] ? one_q : zero_q;
				bit_end = (bitpos_q + WIDTH_BITS'(1)) == cmd_w_q;
			end
			PH_CMD_INV: begin
				timing  = cmd_sh_q[0] ? zero_q : one_q;
				bit_end = (bitpos_q + WIDTH_BITS'(1)) == cmd_w_q;
			end
			PH_STOP: timing = stop_q;
			default: timing = leader_q;
		endcase
	end

	assign is_last = (cnt_q + COUNT_BITS'(1)) == total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bitpos_q <= '0;
			cnt_q    <= '0;
			total_q  <= '0;
		end else if (in_xfer) begin
			phase_q  <= PH_LEADER;
			bitpos_q <= '0;
			cnt_q    <= '0;
			total_q  <= total_d;
		end else if (emit) begin
			cnt_q <= cnt_q + COUNT_BITS'(1);
			if (bit_end) begin
				phase_q  <= phase_after;
				bitpos_q <= '0;
			end else begin
				bitpos_q <= bitpos_q + WIDTH_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			addr_hold_q <= address;
			cmd_hold_q  <= command;
			addr_sh_q   <= address;
			cmd_sh_q    <= command;
		end else if (emit) begin
			if (bit_end) begin
				addr_sh_q <= addr_hold_q;
				cmd_sh_q  <= cmd_hold_q;
			end else if (phase_q == PH_ADDR || phase_q == PH_ADDR_INV) begin
				addr_sh_q <= addr_sh_q >> 1;
			end else begin
				cmd_sh_q <= cmd_sh_q >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mark_q  <= timing[DUR_BITS-1:0];
			space_q <= timing[TIMING_BITS-1:DUR_BITS];
			last_q  <= is_last;
			ok_q    <= is_last && (total_q == expected_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign mark_ticks  = mark_q;
	assign space_ticks = space_q;
	assign last_item   = last_q;
	assign frame_ok    = ok_q;

endmodule

`default_nettype wire

// ===== rtl/irfpe_checker.sv =====
// ============================================================================
// irfpe_checker
// Port-level checks of the infrared frame pulse encoder, bound to the top.
// ============================================================================
`default_nettype none

module irfpe_checker
	import irfpe_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [DUR_BITS-1:0] mark_ticks,
	input wire logic [DUR_BITS-1:0] space_ticks,
	input wire logic                last_item,
	input wire logic                frame_ok
);

	// hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mark_ticks)
			&& $stable(space_ticks) && $stable(last_item))
		else $error("stalled output item changed");

	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_ok |-> last_item)
		else $error("frame_ok on an item that is not last");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("frame transfer not followed by a busy encoder");

	a_idle_tail: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last_item)
		else $error("encoder idle with a frame item pending");

endmodule

bind ir_frame_pulse_encoder irfpe_checker u_irfpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.mark_ticks  (mark_ticks),
	.space_ticks (space_ticks),
	.last_item   (last_item),
	.frame_ok    (frame_ok)
);

`default_nettype wire

// ===== test/ir_frame_pulse_encoder_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ir_frame_pulse_encoder_tb
// Sends address/command requests into the infrared frame pulse encoder and
// checks every mark/space pulse against a frame built from the current timing,
// width and format settings. Directed frames cover reset values, extreme
// timings, zero and full widths and every format option. Random batches
// follow, each under a fresh register setup and with random gaps and stalls.
// ============================================================================

module ir_frame_pulse_encoder_tb;
	import irfpe_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [FIELD_BITS-1:0] addr;
		logic [FIELD_BITS-1:0] cmd;
	} frame_req_t;

	typedef struct packed {
		logic [DUR_BITS-1:0] mark;
		logic [DUR_BITS-1:0] space;
		logic                last;
		logic                ok;
	} pulse_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [INDEX_BITS-1:0]  cfg_index = '0;
	logic [TIMING_BITS-1:0] cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [FIELD_BITS-1:0]  address = '0;
	logic [FIELD_BITS-1:0]  command = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [DUR_BITS-1:0]    mark_ticks;
	logic [DUR_BITS-1:0]    space_ticks;
	logic                   last_item;
	logic                   frame_ok;

	// register image
	logic [TIMING_BITS-1:0] leader_tm = '0;
	logic [TIMING_BITS-1:0] one_tm = '0;
	logic [TIMING_BITS-1:0] zero_tm = '0;
	logic [TIMING_BITS-1:0] stop_tm = '0;
	logic [WIDTH_BITS-1:0]  addr_bits = 4'd8;
	logic [WIDTH_BITS-1:0]  cmd_bits = 4'd8;
	logic [FLAG_BITS-1:0]   fmt = 3'd7;
	logic [COUNT_BITS-1:0]  good_count = 6'd34;

	frame_req_t  frame_requests[$];
	pulse_t      pulse_q[$];
	frame_req_t  req;
	pulse_t      want;
	pulse_t      got;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned fail_count = 0;
	int unsigned total_frames = 0;
	int unsigned cycle_count = 0;
	bit          send_gaps_on = 1'b1;
	bit          ready_stalls_on = 1'b1;

	ir_frame_pulse_encoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.address     (address),
		.command     (command),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mark_ticks  (mark_ticks),
		.space_ticks (space_ticks),
		.last_item   (last_item),
		.frame_ok    (frame_ok)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned draw_idle(bit enable);
		int unsigned r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [TIMING_BITS-1:0] draw_timing();
		logic [TIMING_BITS-1:0] v;
		int unsigned r;
		v = TIMING_BITS'($urandom);
		r = $urandom_range(0, 9);
		if (r == 0)
			v = '0;
		else if (r == 1)
			v = '1;
		return v;
	endfunction

	function automatic logic [TIMING_BITS-1:0] draw_reg(int unsigned max);
		logic [TIMING_BITS-1:0] v;
		v = TIMING_BITS'($urandom);
		if ($urandom_range(0, 7) != 0)
			v = TIMING_BITS'($urandom_range(0, max));
		return v;
	endfunction

	function automatic logic [FIELD_BITS-1:0] draw_field();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return FIELD_BITS'($urandom_range(0, 32767));
	endfunction

	// build the pulse run of one frame under the current register image
	function automatic void encode_frame(logic [FIELD_BITS-1:0] addr,
			logic [FIELD_BITS-1:0] cmd);
		logic [TIMING_BITS-1:0] seq[$];
		pulse_t p;
		int n;
		seq.push_back(leader_tm);
		for (int i = 0; i < addr_bits; i++)
			seq.push_back(addr[i] ? one_tm : zero_tm);
		if (fmt[FLAG_ADDR_INV])
			for (int i = 0; i < addr_bits; i++)
				seq.push_back(addr[i] ? zero_tm : one_tm);
		for (int i = 0; i < cmd_bits; i++)
			seq.push_back(cmd[i] ? one_tm : zero_tm);
		if (fmt[FLAG_CMD_INV])
			for (int i = 0; i < cmd_bits; i++)
				seq.push_back(cmd[i] ? zero_tm : one_tm);
		if (fmt[FLAG_STOP])
			seq.push_back(stop_tm);
		n = seq.size();
		foreach (seq[k]) begin
			p.mark = seq[k][DUR_BITS-1:0];
			p.space = seq[k][TIMING_BITS-1:DUR_BITS];
			p.last = (k == n - 1);
			p.ok = (k == n - 1) && (n == good_count);
			pulse_q.push_back(p);
		end
	endfunction

	task automatic set_reg(cfg_index_t idx, logic [TIMING_BITS-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_LEADER:   leader_tm = val;
			REG_ONE:      one_tm = val;
			REG_ZERO:     zero_tm = val;
			REG_STOP:     stop_tm = val;
			REG_ADDR_W:   addr_bits = val[WIDTH_BITS-1:0];
			REG_CMD_W:    cmd_bits = val[WIDTH_BITS-1:0];
			REG_FORMAT:   fmt = val[FLAG_BITS-1:0];
			REG_EXPECTED: good_count = val[COUNT_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_frame(logic [FIELD_BITS-1:0] addr, logic [FIELD_BITS-1:0] cmd);
		frame_req_t r;
		r.addr = addr;
		r.cmd = cmd;
		frame_requests.push_back(r);
		total_frames++;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (frame_requests.size() != 0 || in_valid || pulse_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic randomize_setup();
		int frame_len;
		set_reg(REG_LEADER, draw_timing());
		set_reg(REG_ONE, draw_timing());
		set_reg(REG_ZERO, draw_timing());
		set_reg(REG_STOP, draw_timing());
		set_reg(REG_ADDR_W, draw_reg(15));
		set_reg(REG_CMD_W, draw_reg(15));
		set_reg(REG_FORMAT, draw_reg(7));
		frame_len = 1 + addr_bits * (1 + fmt[FLAG_ADDR_INV])
			+ cmd_bits * (1 + fmt[FLAG_CMD_INV]) + fmt[FLAG_STOP];
		if ($urandom_range(0, 1) == 0)
			set_reg(REG_EXPECTED, TIMING_BITS'(frame_len));
		else
			set_reg(REG_EXPECTED, draw_reg(63));
		close_writes();
		send_gaps_on = ($urandom_range(0, 3) != 0);
		ready_stalls_on = ($urandom_range(0, 3) != 0);
	endtask

	// sender: hold each request until its transfer, then idle a random gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				encode_frame(address, command);
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (frame_requests.size() != 0) begin
				req = frame_requests.pop_front();
				in_valid <= 1'b1;
				address <= req.addr;
				command <= req.cmd;
				gap_left <= draw_idle(send_gaps_on);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: check each pulse transfer, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.mark = mark_ticks;
				got.space = space_ticks;
				got.last = last_item;
				got.ok = frame_ok;
				if (pulse_q.size() == 0) begin
					$display("%0t: unexpected pulse mark %0d space %0d last %b ok %b",
						$time, got.mark, got.space, got.last, got.ok);
					fail_count++;
				end else begin
					want = pulse_q.pop_front();
					if (got !== want) begin
						$display("%0t: pulse expected mark %0d space %0d last %b ok %b",
							$time, want.mark, want.space, want.last, want.ok);
						$display("%0t: pulse actual   mark %0d space %0d last %b ok %b",
							$time, got.mark, got.space, got.last, got.ok);
						fail_count++;
					end
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= draw_idle(ready_stalls_on);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d pulses outstanding", $time, pulse_q.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: zero timings, 8-bit fields, full format
		send_frame('1, '0);
		send_frame('0, '1);
		wait_drained();

		set_reg(REG_LEADER, {15'd4500, 15'd9000});
		set_reg(REG_ONE, {15'd1687, 15'd562});
		set_reg(REG_ZERO, {15'd562, 15'd562});
		set_reg(REG_STOP, {15'd0, 15'd562});
		set_reg(REG_ADDR_W, 30'd8);
		set_reg(REG_CMD_W, 30'd8);
		set_reg(REG_FORMAT, '1);
		set_reg(REG_EXPECTED, 30'd34);
		close_writes();
		send_frame('0, '0);
		send_frame('1, '1);
		send_frame(15'h5555, 15'h2AAA);
		send_frame(15'h00A5, 15'h003C);
		wait_drained();

		// longest frame; high bits of wide writes drop
		set_reg(REG_LEADER, '1);
		set_reg(REG_ONE, {15'h7FFF, 15'h0000});
		set_reg(REG_ZERO, {15'h0000, 15'h7FFF});
		set_reg(REG_STOP, '0);
		set_reg(REG_ADDR_W, '1);
		set_reg(REG_CMD_W, 30'h3FFF_FFFF);
		set_reg(REG_FORMAT, 30'h3FFF_FFFF);
		set_reg(REG_EXPECTED, 30'h2AAA_AAFE);
		close_writes();
		send_frame('1, '0);
		send_frame('0, '1);
		send_frame(15'h1234, 15'h4321);
		wait_drained();

		// zero widths: leader only
		set_reg(REG_ADDR_W, 30'd16);
		set_reg(REG_CMD_W, 30'h3FFF_FFF0);
		set_reg(REG_FORMAT, '0);
		set_reg(REG_EXPECTED, 30'd1);
		close_writes();
		send_frame('1, '1);
		send_frame(15'h2AAA, 15'h5555);
		wait_drained();

		// zero widths, full format: leader and stop, wrong count
		set_reg(REG_FORMAT, '1);
		set_reg(REG_EXPECTED, 30'd63);
		close_writes();
		send_frame('1, '0);
		send_frame('0, '1);
		wait_drained();

		// inverted command copy only
		set_reg(REG_ADDR_W, 30'd1);
		set_reg(REG_CMD_W, 30'd15);
		set_reg(REG_FORMAT, 30'(1 << FLAG_CMD_INV));
		set_reg(REG_EXPECTED, 30'd32);
		close_writes();
		send_frame(15'h0001, 15'h7FFE);
		send_frame(15'h7FFE, 15'h0001);
		wait_drained();

		// inverted address copy and stop only
		set_reg(REG_ADDR_W, 30'd15);
		set_reg(REG_CMD_W, 30'd3);
		set_reg(REG_FORMAT, 30'((1 << FLAG_ADDR_INV) | (1 << FLAG_STOP)));
		set_reg(REG_EXPECTED, 30'd0);
		close_writes();
		send_frame(15'h4001, 15'h0005);
		send_frame(15'h3FFE, 15'h7FFA);
		wait_drained();

		while (total_frames < 200) begin
			randomize_setup();
			repeat ($urandom_range(8, 22))
				send_frame(draw_field(), draw_field());
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
